// ----- rtl/ice_layer_force_detector_unit_assert.svh -----
// assertion macros shared by the ice layer force detector rtl
`ifndef ICE_LAYER_FORCE_DETECTOR_UNIT_ASSERT_SVH
`define ICE_LAYER_FORCE_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define ILFD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ice detector check failed");

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define ILFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ice detector check failed");

`endif

// ----- rtl/ilfd_pkg.sv -----
// types, constants and register codes of the ice layer force detector
`default_nettype none

package ilfd_pkg;

    // sample and register widths
    localparam int DATA_W  = 16;
    localparam int RATIO_W = 6;
    localparam int LEN_W   = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;

    // default baseline length in samples
    localparam int ILFD_BASELINE_SAMPLES = 5;

    // stream packing
    localparam int S_TDATA_W = 2 * DATA_W;
    localparam int M_TDATA_W = 24;

    // register reset values
    localparam logic [RATIO_W-1:0] ENTER_RESET = RATIO_W'(13);
    localparam logic [RATIO_W-1:0] EXIT_RESET  = RATIO_W'(11);
    localparam logic [LEN_W-1:0]   MIN_RESET   = LEN_W'(4);

    // register indexes
    localparam logic [IDX_W-1:0] CFG_ENTER_RATIO = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_EXIT_RATIO  = IDX_W'(1);
    localparam logic [IDX_W-1:0] CFG_MIN_ICE     = IDX_W'(2);

    typedef enum logic [1:0] {
        V_UNSAFE       = 2'd0,
        V_SAFE         = 2'd1,
        V_INCONCLUSIVE = 2'd2
    } t_verdict;

    typedef enum logic [2:0] {
        PH_SEEK_MOVE  = 3'd0,
        PH_BASELINE   = 3'd1,
        PH_SEEK_START = 3'd2,
        PH_SEEK_END   = 3'd3,
        PH_DONE       = 3'd4
    } t_phase;

    // threshold compare results for the current force
    typedef struct packed {
        logic above_enter;
        logic below_exit;
    } t_thresh_flags;

    // control status seen by the top level
    typedef struct packed {
        t_phase   phase;
        t_verdict verdict;
    } t_ctrl_stat;

endpackage

`default_nettype wire

// ----- rtl/ilfd_thresh.sv -----
// exact ice start and ice end threshold compares by cross multiplication
`default_nettype none

module ilfd_thresh
    import ilfd_pkg::*;
#(
    parameter int BASELINE_SAMPLES = ILFD_BASELINE_SAMPLES
) (
    input  wire logic signed [DATA_W-1:0]                                i_force,
    input  wire logic signed [DATA_W+$clog2(BASELINE_SAMPLES)-1:0]       i_sum,
    input  wire logic        [RATIO_W-1:0]                               i_enter_ratio,
    input  wire logic        [RATIO_W-1:0]                               i_exit_ratio,
    output t_thresh_flags                                                o_flags
);

    localparam int SUM_W       = DATA_W + $clog2(BASELINE_SAMPLES);
    localparam int CMP_W       = SUM_W + 9;
    localparam int FORCE_SCALE = 10 * BASELINE_SAMPLES;

    logic signed [CMP_W-1:0] w_force_x;
    logic signed [CMP_W-1:0] w_sum_x;
    logic signed [CMP_W-1:0] w_scale;
    logic signed [CMP_W-1:0] w_enter_x;
    logic signed [CMP_W-1:0] w_exit_x;
    logic signed [CMP_W-1:0] w_lhs;
    logic signed [CMP_W-1:0] w_rhs_enter;
    logic signed [CMP_W-1:0] w_rhs_exit;

    // sign extend force and sum, zero extend ratios to the compare width
    assign w_force_x = {{(CMP_W-DATA_W){i_force[DATA_W-1]}}, i_force};
    assign w_sum_x   = {{(CMP_W-SUM_W){i_sum[SUM_W-1]}}, i_sum};
    assign w_scale   = CMP_W'(FORCE_SCALE);
    assign w_enter_x = {{(CMP_W-RATIO_W){1'b0}}, i_enter_ratio};
    assign w_exit_x  = {{(CMP_W-RATIO_W){1'b0}}, i_exit_ratio};

    // force times ten times baseline length against sum times ratio
    assign w_lhs       = w_force_x * w_scale;
    assign w_rhs_enter = w_sum_x * w_enter_x;
    assign w_rhs_exit  = w_sum_x * w_exit_x;

    assign o_flags.above_enter = (w_lhs > w_rhs_enter);
    assign o_flags.below_exit  = (w_lhs < w_rhs_exit);

endmodule

`default_nettype wire

// ----- rtl/ilfd_ctrl.sv -----
// phase sequencer with baseline sum, ice counter and latched verdict
`default_nettype none

module ilfd_ctrl
    import ilfd_pkg::*;
#(
    parameter int BASELINE_SAMPLES = ILFD_BASELINE_SAMPLES
) (
    input  wire logic                                              i_clk,
    input  wire logic                                              i_rst_n,
    input  wire logic                                              i_step,
    input  wire logic signed [DATA_W-1:0]                          i_dist,
    input  wire logic signed [DATA_W-1:0]                          i_force,
    input  wire t_thresh_flags                                     i_flags,
    input  wire logic        [LEN_W-1:0]                           i_min_ice,
    output logic signed [DATA_W+$clog2(BASELINE_SAMPLES)-1:0]      o_sum,
    output t_verdict                                               o_verdict,
    output logic        [LEN_W-1:0]                                o_len,
    output t_ctrl_stat                                             o_stat
);

    localparam int SUM_W = DATA_W + $clog2(BASELINE_SAMPLES);
    localparam int CNT_W = $clog2(BASELINE_SAMPLES + 1);

    t_phase                   r_phase,   n_phase;
    logic [CNT_W-1:0]         r_cnt,     n_cnt;
    logic signed [SUM_W-1:0]  r_sum,     n_sum;
    logic [LEN_W-1:0]         r_ice,     n_ice;
    t_verdict                 r_verdict, n_verdict;

    logic signed [SUM_W-1:0]  w_force_x;
    logic [CNT_W:0]           w_cnt_inc;
    logic [LEN_W-1:0]         w_ice_inc;

    assign w_force_x = {{(SUM_W-DATA_W){i_force[DATA_W-1]}}, i_force};
    assign w_cnt_inc = {1'b0, r_cnt} + (CNT_W+1)'(1);
    // ice length saturates at full scale
    assign w_ice_inc = (r_ice == {LEN_W{1'b1}}) ? r_ice : r_ice + LEN_W'(1);

    // state registers, advanced once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SEEK_MOVE;
            r_cnt     <= '0;
            r_sum     <= '0;
            r_ice     <= '0;
            r_verdict <= V_INCONCLUSIVE;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_sum     <= n_sum;
            r_ice     <= n_ice;
            r_verdict <= n_verdict;
        end
    end

    // next state for the item now at the input register
    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_sum     = r_sum;
        n_ice     = r_ice;
        n_verdict = r_verdict;
        unique case (r_phase)
            PH_SEEK_MOVE: begin
                if (i_dist > 0) begin
                    n_sum   = w_force_x;
                    n_cnt   = CNT_W'(1);
                    n_phase = (BASELINE_SAMPLES <= 1) ? PH_SEEK_START : PH_BASELINE;
                end
            end
            PH_BASELINE: begin
                n_sum = r_sum + w_force_x;
                n_cnt = w_cnt_inc[CNT_W-1:0];
                if (w_cnt_inc >= (CNT_W+1)'(BASELINE_SAMPLES)) begin
                    n_phase = PH_SEEK_START;
                end
            end
            PH_SEEK_START: begin
                if (i_flags.above_enter) begin
                    n_ice = '0;
                    // start sample may close the ice at length zero
                    if (i_flags.below_exit) begin
                        n_verdict = V_UNSAFE;
                        n_phase   = PH_DONE;
                    end else begin
                        n_phase = PH_SEEK_END;
                    end
                end
            end
            PH_SEEK_END: begin
                n_ice = w_ice_inc;
                if (i_flags.below_exit) begin
                    n_verdict = (w_ice_inc > i_min_ice) ? V_SAFE : V_UNSAFE;
                    n_phase   = PH_DONE;
                end
            end
            default: begin
            end
        endcase
    end

    // result for this item
    assign o_sum     = r_sum;
    assign o_verdict = n_verdict;
    assign o_len     = (n_phase == PH_SEEK_END || n_phase == PH_DONE) ? n_ice : '0;

    assign o_stat.phase   = r_phase;
    assign o_stat.verdict = r_verdict;

endmodule

`default_nettype wire

// ----- rtl/ice_layer_force_detector_unit.sv -----
// top level of the ice layer force detector: registers, handshakes and checks
//
//  channel   dir  handshake                 payload
//  s stream  in   i_s_tvalid/o_s_tready     i_s_tdata: distance, force
//  m stream  out  o_m_tvalid/i_m_tready     o_m_tdata: verdict, ice length
//  config    in   i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
//
// one item per cycle sustained while the result side is not stalled; an item
// passes from the input register to the result register through the
// threshold multipliers and the phase logic between the two registers.
// synchronous active-low reset restores phase, counters and register defaults.
// a stalled result holds the input register; the input side stays ready while
// the input register is empty or moves on.
`default_nettype none

`include "ice_layer_force_detector_unit_assert.svh"

module ice_layer_force_detector_unit
    import ilfd_pkg::*;
#(
    parameter int BASELINE_SAMPLES = ILFD_BASELINE_SAMPLES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [S_TDATA_W-1:0]  i_s_tdata,   // actuator_distance, drill_force
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]       o_m_tdata,   // verdict, ice_length, zero pad
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [IDX_W-1:0]      i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);

    localparam int SUM_W = DATA_W + $clog2(BASELINE_SAMPLES);
    localparam int PAD_W = M_TDATA_W - 2 - LEN_W;

    logic [RATIO_W-1:0]       r_enter_ratio;
    logic [RATIO_W-1:0]       r_exit_ratio;
    logic [LEN_W-1:0]         r_min_ice;

    logic                     r_in_valid;
    logic signed [DATA_W-1:0] r_in_dist;
    logic signed [DATA_W-1:0] r_in_force;

    logic                     r_out_valid;
    t_verdict                 r_out_verdict;
    logic [LEN_W-1:0]         r_out_len;

    logic                     w_advance;
    logic signed [SUM_W-1:0]  w_sum;
    t_thresh_flags            w_flags;
    t_verdict                 w_verdict;
    logic [LEN_W-1:0]         w_len;
    t_ctrl_stat               w_stat;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter_ratio <= ENTER_RESET;
            r_exit_ratio  <= EXIT_RESET;
            r_min_ice     <= MIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ENTER_RATIO: r_enter_ratio <= i_cfg_data[RATIO_W-1:0];
                CFG_EXIT_RATIO:  r_exit_ratio  <= i_cfg_data[RATIO_W-1:0];
                CFG_MIN_ICE:     r_min_ice     <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // handshake between input register and result register
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_dist  <= i_s_tdata[DATA_W-1:0];
            r_in_force <= i_s_tdata[2*DATA_W-1:DATA_W];
        end
    end

    // threshold compares
    ilfd_thresh #(
        .BASELINE_SAMPLES (BASELINE_SAMPLES)
    ) u_thresh (
        .i_force       (r_in_force),
        .i_sum         (w_sum),
        .i_enter_ratio (r_enter_ratio),
        .i_exit_ratio  (r_exit_ratio),
        .o_flags       (w_flags)
    );

    // phase sequencer
    ilfd_ctrl #(
        .BASELINE_SAMPLES (BASELINE_SAMPLES)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_advance),
        .i_dist    (r_in_dist),
        .i_force   (r_in_force),
        .i_flags   (w_flags),
        .i_min_ice (r_min_ice),
        .o_sum     (w_sum),
        .o_verdict (w_verdict),
        .o_len     (w_len),
        .o_stat    (w_stat)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_verdict <= w_verdict;
            r_out_len     <= w_len;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_out_len, r_out_verdict};

    // a finished run always carries a decided verdict
    `ILFD_ASSERT_NOW(a_done_has_verdict, w_stat.phase == PH_DONE,
        w_stat.verdict != V_INCONCLUSIVE)
    // the done phase is never left
    `ILFD_ASSERT_NEXT(a_done_sticks, w_stat.phase == PH_DONE, w_stat.phase == PH_DONE)
    // a held item stays in the input register unchanged
    `ILFD_ASSERT_NEXT(a_in_held, r_in_valid && !w_advance,
        r_in_valid && $stable(r_in_force) && $stable(r_in_dist))

endmodule

`default_nettype wire
